// ===== rtl/ita_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_pkg: shared definitions of the integer to ASCII formatter
// Conversion codes, character constants, default sizes and the control
// bundle of the digit conversion unit.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int DEF_VALUE_BITS = 16;
    localparam int DEF_MAX_WIDTH  = 32;
    localparam int FUNC_W         = 3;
    localparam int CHAR_W         = 8;
    localparam int FWIDTH_W       = 6;

    localparam logic [FUNC_W-1:0] FUNC_SDEC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDEC = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEXL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_HEXU = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

    localparam logic [3:0] DIGIT_TEN = 4'hA;

    typedef struct packed {
        logic load;
        logic step;
        logic dec;
    } dab_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
            c = CH_ZERO + CHAR_W'(d);
        else if (upper)
            c = CH_UPPER_A + CHAR_W'(d - DIGIT_TEN);
        else
            c = CH_LOWER_A + CHAR_W'(d - DIGIT_TEN);
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ita_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_in_if: input channel of the formatter
// Valid/ready channel carrying one value with its conversion kind and format.
// ----------------------------------------------------------------------------
interface ita_in_if
    import ita_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [VALUE_BITS-1:0] value;
    logic [CHAR_W-1:0]     fill;
    logic [FWIDTH_W-1:0]   field_width;

    modport source (output valid, output func, output value, output fill,
                    output field_width, input ready);
    modport sink   (input valid, input func, input value, input fill,
                    input field_width, output ready);
endinterface
`default_nettype wire

// ===== rtl/ita_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_out_if: character channel of the formatter
// Valid/ready channel carrying one character and an end-of-text mark.
// ----------------------------------------------------------------------------
interface ita_out_if
    import ita_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ita_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_dabble: bit-serial radix conversion unit
// Shifts the magnitude in one bit per cycle while step is high, most
// significant first, into a nibble register; in decimal mode each nibble of
// five or more gets three added before the shift; counts significant digits.
// ----------------------------------------------------------------------------
module ita_dabble
    import ita_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int DIGITS     = DEF_VALUE_BITS / 3 + 1,
    localparam int NDW       = $clog2(DIGITS + 1),
    localparam int IXW       = $clog2(DIGITS)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dab_ctrl_t             ctrl,
    input  wire logic [VALUE_BITS-1:0] load_value,
    output logic      [DIGITS*4-1:0]   digits,
    output logic      [NDW-1:0]        num_digits
);

    logic [VALUE_BITS-1:0] sh_reg;
    logic [DIGITS*4-1:0]   bcd_reg;
    logic [NDW-1:0]        nd_reg;
    logic [DIGITS*4-1:0]   adj;
    logic [DIGITS*4-1:0]   bcd_next;
    logic                  grow;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (ctrl.dec && (bcd_reg[i*4 +: 4] >= 4'd5))
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
        bcd_next = {adj[DIGITS*4-2:0], sh_reg[VALUE_BITS-1]};
        // The value at most doubles per step, so it gains at most one digit.
        grow = (nd_reg < NDW'(DIGITS)) && (bcd_next[nd_reg[IXW-1:0]*4 +: 4] != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg  <= '0;
            bcd_reg <= '0;
            nd_reg  <= NDW'(1);
        end
        else if (ctrl.load)
        begin
            sh_reg  <= load_value;
            bcd_reg <= '0;
            nd_reg  <= NDW'(1);
        end
        else if (ctrl.step)
        begin
            sh_reg  <= {sh_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= bcd_next;
            if (grow)
                nd_reg <= nd_reg + NDW'(1);
        end
    end

    assign digits     = bcd_reg;
    assign num_digits = nd_reg;

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style %d %u %x %X %c formatter
// Turns one value into a burst of ASCII characters with leading fill.
// ----------------------------------------------------------------------------
// A numeric item passes from its transfer on din through ST_CONV, where the
// shift-and-adjust conversion unit handles one bit of the value per cycle,
// ST_PREP, which sets up the padding count, and ST_EMIT, where one character
// leaves per cycle while dout is not stalled; then the block is ready again.
// A character item goes straight to ST_EMIT and an unused kind is dropped.
// Characters pass through an output register, so the final character of one
// item may still wait on dout while the next item is taken. Fill characters
// come before the minus sign, so zero fill of -5 to width five gives "000-5".
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import ita_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input wire logic clk,
    input wire logic rst_n,
    ita_in_if.sink   din,
    ita_out_if.source dout
);

    localparam int DIGITS = VALUE_BITS / 3 + 1;
    localparam int NDW    = $clog2(DIGITS + 1);
    localparam int IXW    = $clog2(DIGITS);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int BCW    = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [BCW-1:0]    bc_reg;
    logic              neg_reg;
    logic              upper_reg;
    logic              dec_reg;
    logic              char_mode_reg;
    logic [CHAR_W-1:0] chr_reg;
    logic [CHAR_W-1:0] fill_reg;
    logic [WW-1:0]     width_reg;
    logic [WW-1:0]     pad_reg;
    logic [IXW-1:0]    idx_reg;
    logic              ov_reg;
    logic [CHAR_W-1:0] oc_reg;
    logic              ol_reg;

    dab_ctrl_t             dab_ctrl;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGITS*4-1:0]   dab_digits;
    logic [NDW-1:0]        dab_nd;
    logic                  accept;
    logic                  numeric;
    logic                  out_free;
    logic                  load_out;
    logic [3:0]            cur_digit;
    logic [CHAR_W-1:0]     cur_ch;
    logic [7:0]            used;
    logic [7:0]            width8;

    assign din.ready = (state_reg == ST_IDLE);
    assign accept    = din.valid && din.ready;
    assign numeric   = (din.func <= FUNC_HEXU);
    assign out_free  = !ov_reg || dout.ready;
    assign load_out  = (state_reg == ST_EMIT) && out_free;

    // Two's complement magnitude; the most negative value maps onto itself.
    assign mag = ((din.func == FUNC_SDEC) && din.value[VALUE_BITS-1]) ?
                 (~din.value + VALUE_BITS'(1)) : din.value;

    assign dab_ctrl = '{load: accept && numeric,
                        step: (state_reg == ST_CONV),
                        dec:  dec_reg};

    ita_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dab_ctrl),
        .load_value (mag),
        .digits     (dab_digits),
        .num_digits (dab_nd)
    );

    assign cur_digit = dab_digits[idx_reg*4 +: 4];
    assign cur_ch    = digit_char(cur_digit, upper_reg);
    assign used      = 8'(dab_nd) + 8'(neg_reg);
    assign width8    = 8'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            dec_reg       <= 1'b0;
            char_mode_reg <= 1'b0;
            chr_reg       <= '0;
            fill_reg      <= '0;
            width_reg     <= '0;
            pad_reg       <= '0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
            oc_reg        <= '0;
            ol_reg        <= 1'b0;
        end
        else
        begin
            if (load_out)
                ov_reg <= 1'b1;
            else if (dout.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (din.func == FUNC_CHAR)
                        begin
                            char_mode_reg <= 1'b1;
                            chr_reg       <= din.value[7:0];
                            state_reg     <= ST_EMIT;
                        end
                        else if (numeric)
                        begin
                            char_mode_reg <= 1'b0;
                            neg_reg   <= (din.func == FUNC_SDEC) && din.value[VALUE_BITS-1];
                            upper_reg <= (din.func == FUNC_HEXU);
                            dec_reg   <= (din.func == FUNC_SDEC) || (din.func == FUNC_UDEC);
                            fill_reg  <= din.fill;
                            if (8'(din.field_width) > 8'(MAX_WIDTH))
                                width_reg <= WW'(MAX_WIDTH);
                            else
                                width_reg <= WW'(din.field_width);
                            bc_reg    <= BCW'(VALUE_BITS);
                            state_reg <= ST_CONV;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_CONV:
                begin
                    bc_reg <= bc_reg - BCW'(1);
                    if (bc_reg == BCW'(1))
                        state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    if (width8 > used)
                        pad_reg <= WW'(width8 - used);
                    else
                        pad_reg <= '0;
                    idx_reg   <= IXW'(dab_nd - NDW'(1));
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        priority if (char_mode_reg)
                        begin
                            oc_reg    <= chr_reg;
                            ol_reg    <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else if (pad_reg != '0)
                        begin
                            oc_reg  <= fill_reg;
                            ol_reg  <= 1'b0;
                            pad_reg <= pad_reg - WW'(1);
                        end
                        else if (neg_reg)
                        begin
                            oc_reg  <= CH_MINUS;
                            ol_reg  <= 1'b0;
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            oc_reg <= cur_ch;
                            ol_reg <= (idx_reg == '0);
                            if (idx_reg == '0)
                                state_reg <= ST_IDLE;
                            else
                                idx_reg <= idx_reg - IXW'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign dout.valid    = ov_reg;
    assign dout.out_char = oc_reg;
    assign dout.last     = ol_reg;

    // An unused kind is dropped and the block stays ready.
    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (din.func > FUNC_CHAR)) |=> din.ready)
        else $error("unused kind did not leave the block ready");

    // A numeric transfer starts a conversion that blocks further input.
    a_numeric_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && numeric) |=> (!din.ready && (state_reg == ST_CONV)))
        else $error("numeric transfer did not start a conversion");

    // The digit count stays between one and the size of the digit register.
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> ((dab_nd != '0) && (dab_nd <= NDW'(DIGITS))))
        else $error("digit count out of range");

endmodule
`default_nettype wire
